/* rtl/rgb_colour_fader_with_breathing_assert.svh */
// Assertion macros for the RGB colour fader with breathing.
// Included by the RTL modules that check their own logic; needs clk and rst_n in scope.
`ifndef RGB_COLOUR_FADER_WITH_BREATHING_ASSERT_SVH
`define RGB_COLOUR_FADER_WITH_BREATHING_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define RGBF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define RGBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RGBF_ASSERT_SAME(label, ante, cons, msg)
`define RGBF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/rgbf_pkg.sv */
// Shared types and constants for the RGB colour fader with breathing.
// No dependencies; imported by every module of the block.
package rgbf_pkg;

  localparam int DUTY_W   = 6;
  localparam int BREATH_W = 10;
  localparam int LEVEL_W  = 11;
  localparam int PERIOD_W = 16;
  localparam int ACC_W    = 16;

  localparam logic [DUTY_W-1:0]   DUTY_MAX      = 6'd63;
  localparam logic [BREATH_W-1:0] BREATH_MAX    = 10'd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST_MS = 16'd1000;

  // acc / 100 for any 16-bit acc: (acc * 83887) >> 23
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam int          DIV100_SHIFT = 23;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FADE_PERIOD   = 1'b0,
    REG_BREATH_PERIOD = 1'b1
  } reg_idx_e;

  // item kinds carried in tuser
  typedef enum logic [0:0] {
    CMD_TICK   = 1'b0,
    CMD_COLOUR = 1'b1
  } cmd_e;

  // colour indexes; codes above the last one are ignored
  typedef enum logic [2:0] {
    COL_OFF    = 3'd0,
    COL_CYAN   = 3'd1,
    COL_PURPLE = 3'd2,
    COL_ORANGE = 3'd3,
    COL_WHITE  = 3'd4,
    COL_YELLOW = 3'd5
  } colour_e;

  localparam logic [2:0] COLOUR_LAST = 3'd5;

  // percentage levels used by the colour table
  typedef enum logic [1:0] {
    PCT_0   = 2'd0,
    PCT_15  = 2'd1,
    PCT_50  = 2'd2,
    PCT_100 = 2'd3
  } pct_e;

  typedef pct_e rgb_pct_t [3];

  // decoded item control
  typedef struct packed {
    logic       tick;
    logic       sel;
    logic [2:0] colour;
  } rgbf_ctl_t;

  // one result item, packed in tdata order (red lowest)
  typedef struct packed {
    logic                fading;
    logic [BREATH_W-1:0] breath_duty;
    logic [DUTY_W-1:0]   blue_duty;
    logic [DUTY_W-1:0]   green_duty;
    logic [DUTY_W-1:0]   red_duty;
  } rgbf_result_t;

  // red, green, blue percentages of each colour
  function automatic rgb_pct_t colour_pct(input logic [2:0] colour);
    rgb_pct_t p;
    unique case (colour)
      COL_CYAN:   p = '{PCT_0,   PCT_100, PCT_100};
      COL_PURPLE: p = '{PCT_100, PCT_0,   PCT_100};
      COL_ORANGE: p = '{PCT_100, PCT_15,  PCT_0};
      COL_WHITE:  p = '{PCT_100, PCT_100, PCT_100};
      COL_YELLOW: p = '{PCT_100, PCT_50,  PCT_0};
      default:    p = '{PCT_0,   PCT_0,   PCT_0};
    endcase
    return p;
  endfunction

endpackage

/* rtl/rgbf_timer.sv */
// Step timer: holds one period register (stored as ms / FADE_STEPS) and a tick counter.
// Depends on rgbf_pkg.
module rgbf_timer #(
  parameter int FADE_STEPS = 50
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          set_en,
  input  logic [rgbf_pkg::PERIOD_W-1:0] set_ms,
  input  logic                          tick,
  output logic                          step
);
  import rgbf_pkg::*;

  // exact ms / FADE_STEPS for 16-bit ms by reciprocal multiply
  localparam int     L_BITS   = $clog2(FADE_STEPS);
  localparam int     Q_SHIFT  = PERIOD_W + L_BITS;
  localparam longint Q_MUL    = ((64'd1 << Q_SHIFT) + FADE_STEPS - 1) / FADE_STEPS;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(PERIOD_RST_MS / FADE_STEPS);

  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] count_r, count_nxt;
  logic [32:0]         q_prod;
  logic [PERIOD_W:0]   count_inc;

  assign q_prod = 33'(set_ms) * 33'(Q_MUL);

  // period register, divided at write time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
    end else if (set_en) begin
      period_r <= PERIOD_W'(q_prod >> Q_SHIFT);
    end
  end

  // counter reaches the period: clear and step
  always_comb begin
    count_inc = {1'b0, count_r} + 1'b1;
    step      = count_inc >= {1'b0, period_r};
    count_nxt = count_r;
    if (tick) begin
      count_nxt = step ? '0 : count_inc[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/rgbf_fader.sv */
// Colour select and per-channel fade for red, green and blue.
// Depends on rgbf_pkg; computes the updated duties and the fading flag of each item.
module rgbf_fader #(
  parameter int FADE_STEPS   = 50,
  parameter int MAX_RGB_DUTY = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rgbf_pkg::rgbf_ctl_t         ctl,
  input  logic                        fstep,
  output logic [rgbf_pkg::DUTY_W-1:0] red_duty,
  output logic [rgbf_pkg::DUTY_W-1:0] green_duty,
  output logic [rgbf_pkg::DUTY_W-1:0] blue_duty,
  output logic                        fading
);
  import rgbf_pkg::*;

  // scaled targets for each percentage level, held at 63
  localparam int T15_RAW  = MAX_RGB_DUTY * 15 / 100;
  localparam int T50_RAW  = MAX_RGB_DUTY * 50 / 100;
  localparam int T100_RAW = MAX_RGB_DUTY * 100 / 100;
  localparam logic [DUTY_W-1:0] T15  = (T15_RAW > 63)  ? DUTY_MAX : DUTY_W'(T15_RAW);
  localparam logic [DUTY_W-1:0] T50  = (T50_RAW > 63)  ? DUTY_MAX : DUTY_W'(T50_RAW);
  localparam logic [DUTY_W-1:0] T100 = (T100_RAW > 63) ? DUTY_MAX : DUTY_W'(T100_RAW);

  // span * 100 / FADE_STEPS as one multiply by a constant and a shift
  localparam int     L_BITS     = $clog2(FADE_STEPS);
  localparam int     STEP_SHIFT = 16 + L_BITS;
  localparam longint RECIP      = ((64'd1 << STEP_SHIFT) + FADE_STEPS - 1) / FADE_STEPS;
  localparam longint STEP_MUL   = 100 * RECIP;
  localparam int     STEP_W     = 13;

  function automatic logic [DUTY_W-1:0] pct_target(input pct_e p);
    logic [DUTY_W-1:0] t;
    unique case (p)
      PCT_15:  t = T15;
      PCT_50:  t = T50;
      PCT_100: t = T100;
      default: t = '0;
    endcase
    return t;
  endfunction

  logic [DUTY_W-1:0] tgt_r   [3];
  logic [DUTY_W-1:0] cur_r   [3];
  logic [STEP_W-1:0] step_r  [3];
  logic [ACC_W-1:0]  acc_r   [3];
  logic [2:0]        last_r;

  logic [DUTY_W-1:0] tgt_nxt  [3];
  logic [DUTY_W-1:0] cur_nxt  [3];
  logic [STEP_W-1:0] step_nxt [3];
  logic [ACC_W-1:0]  acc_nxt  [3];
  logic [2:0]        last_nxt;

  rgb_pct_t          pct;
  logic              sel_ok;
  logic              fading_nxt;
  logic [DUTY_W-1:0] tgt_new  [3];
  logic [DUTY_W-1:0] span     [3];
  logic [29:0]       step_prod[3];
  logic [ACC_W-1:0]  acc_sum  [3];
  logic [32:0]       div_prod [3];

  // next state of the three channels
  always_comb begin
    pct        = colour_pct(ctl.colour);
    sel_ok     = ctl.sel && (ctl.colour <= COLOUR_LAST) && (ctl.colour != last_r);
    last_nxt   = sel_ok ? ctl.colour : last_r;
    fading_nxt = 1'b0;
    for (int ch = 0; ch < 3; ch++) begin
      tgt_new[ch]   = pct_target(pct[ch]);
      span[ch]      = (tgt_new[ch] >= cur_r[ch]) ? tgt_new[ch] - cur_r[ch]
                                                 : cur_r[ch] - tgt_new[ch];
      step_prod[ch] = 30'(span[ch]) * 30'(STEP_MUL);
      acc_sum[ch]   = (cur_r[ch] < tgt_r[ch]) ? acc_r[ch] + ACC_W'(step_r[ch])
                                              : acc_r[ch] - ACC_W'(step_r[ch]);
      div_prod[ch]  = 33'(acc_sum[ch]) * 33'(DIV100_MUL);

      tgt_nxt[ch]  = tgt_r[ch];
      cur_nxt[ch]  = cur_r[ch];
      step_nxt[ch] = step_r[ch];
      acc_nxt[ch]  = acc_r[ch];
      if (sel_ok) begin
        tgt_nxt[ch]  = tgt_new[ch];
        step_nxt[ch] = STEP_W'(step_prod[ch] >> STEP_SHIFT);
      end else if (fstep && (cur_r[ch] != tgt_r[ch])) begin
        acc_nxt[ch] = acc_sum[ch];
        cur_nxt[ch] = DUTY_W'(div_prod[ch] >> DIV100_SHIFT);
      end
      if (cur_nxt[ch] != tgt_nxt[ch]) begin
        fading_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        tgt_r[ch]  <= '0;
        cur_r[ch]  <= '0;
        step_r[ch] <= '0;
        acc_r[ch]  <= '0;
      end
    end else begin
      last_r <= last_nxt;
      for (int ch = 0; ch < 3; ch++) begin
        tgt_r[ch]  <= tgt_nxt[ch];
        cur_r[ch]  <= cur_nxt[ch];
        step_r[ch] <= step_nxt[ch];
        acc_r[ch]  <= acc_nxt[ch];
      end
    end
  end

  // duties as they stand after this item
  assign red_duty   = cur_nxt[0];
  assign green_duty = cur_nxt[1];
  assign blue_duty  = cur_nxt[2];
  assign fading     = fading_nxt;

  `include "rgb_colour_fader_with_breathing_assert.svh"

  `RGBF_ASSERT_SAME(a_last_in_table, 1'b1, last_r <= COLOUR_LAST, "last colour out of table")
  `RGBF_ASSERT_NEXT(a_bad_colour_ignored,
                    ctl.sel && (ctl.colour > COLOUR_LAST),
                    $stable(last_r) && $stable(tgt_r[0]),
                    "ignored colour changed state")

endmodule

/* rtl/rgbf_breath.sv */
// Triangle-wave breathing level, stepped by its timer.
// Depends on rgbf_pkg.
module rgbf_breath #(
  parameter int FADE_STEPS = 50
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          bstep,
  output logic [rgbf_pkg::BREATH_W-1:0] breath_duty
);
  import rgbf_pkg::*;

  localparam logic [LEVEL_W-1:0] BSTEP = LEVEL_W'(1000 / FADE_STEPS);

  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               rising_r, rising_nxt;
  logic [LEVEL_W-1:0] level_up;

  // rise to the top, fall to the bottom; turn at the bottom without moving
  always_comb begin
    level_up   = level_r + BSTEP;
    level_nxt  = level_r;
    rising_nxt = rising_r;
    if (bstep) begin
      if (rising_r) begin
        level_nxt = level_up;
        if (level_up >= LEVEL_W'(BREATH_MAX)) begin
          rising_nxt = 1'b0;
        end
      end else if (level_r >= BSTEP) begin
        level_nxt = level_r - BSTEP;
      end else begin
        rising_nxt = 1'b1;
      end
    end
    breath_duty = (level_nxt > LEVEL_W'(BREATH_MAX)) ? BREATH_MAX
                                                      : level_nxt[BREATH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      rising_r <= 1'b0;
    end else begin
      level_r  <= level_nxt;
      rising_r <= rising_nxt;
    end
  end

  `include "rgb_colour_fader_with_breathing_assert.svh"

  `RGBF_ASSERT_SAME(a_level_bound, 1'b1,
                    level_r < (LEVEL_W'(BREATH_MAX) + BSTEP),
                    "breathing level out of range")

endmodule

/* rtl/rgbf_outbuf.sv */
// Two-entry output buffer (result register plus skid) for result items.
// Depends on rgbf_pkg.
module rgbf_outbuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rgbf_pkg::rgbf_result_t push_data,
  output logic                   can_push,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rgbf_pkg::rgbf_result_t out_data
);
  import rgbf_pkg::*;

  logic         main_v_r, skid_v_r;
  rgbf_result_t main_d_r, skid_d_r;
  logic         pop;

  assign pop       = main_v_r && out_ready;
  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_d_r <= push_data;
      end else begin
        main_d_r <= push_data;
      end
    end
  end

  `include "rgb_colour_fader_with_breathing_assert.svh"

  `RGBF_ASSERT_SAME(a_skid_needs_main, skid_v_r, main_v_r, "skid full while result register empty")
  `RGBF_ASSERT_NEXT(a_stall_fills_skid, push && main_v_r && !out_ready, skid_v_r, "stalled item not held in skid")

endmodule

/* rtl/rgb_colour_fader_with_breathing.sv */
// Top level of the RGB colour fader with breathing.
// Depends on rgbf_pkg, rgbf_timer, rgbf_fader, rgbf_breath and rgbf_outbuf.
//
// Usage:
//   Input items arrive on in_*: in_tuser is the command (0 = 1 ms tick,
//   1 = select colour), in_tdata[2:0] the colour index. Every item gives one
//   result item on out_* with the three RGB duties, the breathing duty and
//   the fading flag, all as they stand after that item.
//   Throughput: one item per cycle while in_tready is high; all channel
//   updates and both step timers finish in the accept cycle, and each
//   result is registered in the output buffer when its item is accepted.
//   A skid entry behind the result register takes one more item while the
//   receiver stalls; in_tready drops only when both entries are full.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index
//   (0 fade period in ms, 1 breathing period in ms) at the clock edge;
//   write only while no item is in flight.
//   Reset: rst_n (synchronous, low) clears all duties, counters and the
//   buffer and loads both periods with 1000 ms.
module rgb_colour_fader_with_breathing #(
  parameter int FADE_STEPS   = 50,
  parameter int MAX_RGB_DUTY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] colour, [7:3] zero
  input  logic [0:0]  in_tuser,   // [0] cmd
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [5:0] red_duty, [11:6] green_duty, [17:12] blue_duty,
                                  // [27:18] breath_duty, [28] fading, [31:29] zero
);
  import rgbf_pkg::*;

  logic         accept;
  rgbf_ctl_t    ctl;
  logic         fstep, bstep;
  logic         fade_set, breath_set;
  rgbf_result_t res;
  rgbf_result_t res_q;

  // decode the accepted item
  assign accept     = in_tvalid && in_tready;
  assign ctl.tick   = accept && (in_tuser == CMD_TICK);
  assign ctl.sel    = accept && (in_tuser == CMD_COLOUR);
  assign ctl.colour = in_tdata[2:0];

  assign fade_set   = cfg_we && (cfg_index == REG_FADE_PERIOD);
  assign breath_set = cfg_we && (cfg_index == REG_BREATH_PERIOD);

  rgbf_timer #(.FADE_STEPS(FADE_STEPS)) u_fade_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .set_en (fade_set),
    .set_ms (cfg_wdata),
    .tick   (ctl.tick),
    .step   (fstep)
  );

  rgbf_timer #(.FADE_STEPS(FADE_STEPS)) u_breath_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .set_en (breath_set),
    .set_ms (cfg_wdata),
    .tick   (ctl.tick),
    .step   (bstep)
  );

  rgbf_fader #(
    .FADE_STEPS   (FADE_STEPS),
    .MAX_RGB_DUTY (MAX_RGB_DUTY)
  ) u_fader (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .fstep      (fstep && ctl.tick),
    .red_duty   (res.red_duty),
    .green_duty (res.green_duty),
    .blue_duty  (res.blue_duty),
    .fading     (res.fading)
  );

  rgbf_breath #(.FADE_STEPS(FADE_STEPS)) u_breath (
    .clk         (clk),
    .rst_n       (rst_n),
    .bstep       (bstep && ctl.tick),
    .breath_duty (res.breath_duty)
  );

  rgbf_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_q)
  );

  assign out_tdata = {3'b000, res_q};

endmodule
